FILE: sv/rbsi_pkg.sv
package rbsi_pkg;

	// Default number format of coordinates and distances: signed Q16.16.
	localparam int RBSI_COORD_WIDTH = 32;
	localparam int RBSI_FRAC_BITS   = 16;

	// Number of axes, and slab lanes (one per box corner per axis).
	localparam int NUM_AXES  = 3;
	localparam int NUM_LANES = 2 * NUM_AXES;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_DIR_X = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_DIR_Y = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_DIR_Z = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_RAY_T_MAX = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 3'd7;

	// Reset value of the tolerance register (about 0.001 in Q16.16).
	localparam int TOLERANCE_RESET = 66;

endpackage

FILE: sv/rbsi_cfg.sv
module rbsi_cfg
	import rbsi_pkg::*;
#(
	parameter int COORD_WIDTH = RBSI_COORD_WIDTH,
	parameter int FRAC_BITS   = RBSI_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]              cfg_index,
	input  logic [COORD_WIDTH-1:0]              cfg_wdata,
	output logic signed [COORD_WIDTH-1:0]       origin [NUM_AXES],
	output logic signed [COORD_WIDTH-1:0]       inv_dir [NUM_AXES],
	output logic signed [COORD_WIDTH-1:0]       ray_t_max,
	output logic [COORD_WIDTH-2:0]              tolerance
);

	localparam logic [COORD_WIDTH-1:0] INV_RESET  = COORD_WIDTH'(1) << FRAC_BITS;
	localparam logic [COORD_WIDTH-1:0] TMAX_RESET = {1'b0, {(COORD_WIDTH-1){1'b1}}};

	logic [COORD_WIDTH-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic [COORD_WIDTH-1:0] inv_x_q, inv_y_q, inv_z_q;
	logic [COORD_WIDTH-1:0] t_max_q;
	logic [COORD_WIDTH-2:0] tol_q;

	// Register file; every index of the port maps to a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			inv_x_q    <= INV_RESET;
			inv_y_q    <= INV_RESET;
			inv_z_q    <= INV_RESET;
			t_max_q    <= TMAX_RESET;
			tol_q      <= (COORD_WIDTH-1)'(TOLERANCE_RESET);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ORIGIN_X:  origin_x_q <= cfg_wdata;
				REG_ORIGIN_Y:  origin_y_q <= cfg_wdata;
				REG_ORIGIN_Z:  origin_z_q <= cfg_wdata;
				REG_INV_DIR_X: inv_x_q    <= cfg_wdata;
				REG_INV_DIR_Y: inv_y_q    <= cfg_wdata;
				REG_INV_DIR_Z: inv_z_q    <= cfg_wdata;
				REG_RAY_T_MAX: t_max_q    <= cfg_wdata;
				REG_TOLERANCE: tol_q      <= cfg_wdata[COORD_WIDTH-2:0];
				default: ;
			endcase
		end
	end

	assign origin[0]  = origin_x_q;
	assign origin[1]  = origin_y_q;
	assign origin[2]  = origin_z_q;
	assign inv_dir[0] = inv_x_q;
	assign inv_dir[1] = inv_y_q;
	assign inv_dir[2] = inv_z_q;
	assign ray_t_max  = t_max_q;
	assign tolerance  = tol_q;

endmodule

FILE: sv/rbsi_slab.sv
module rbsi_slab
	import rbsi_pkg::*;
#(
	parameter int COORD_WIDTH = RBSI_COORD_WIDTH,
	parameter int FRAC_BITS   = RBSI_FRAC_BITS
) (
	input  logic                          clk,
	input  logic signed [COORD_WIDTH-1:0] corner,
	input  logic signed [COORD_WIDTH-1:0] origin,
	input  logic signed [COORD_WIDTH-1:0] inv_dir,
	output logic signed [COORD_WIDTH-1:0] distance
);

	// Widths: difference magnitude, multiplier halves, full product.
	localparam int DW = COORD_WIDTH + 1;
	localparam int IL = COORD_WIDTH / 2;
	localparam int IH = COORD_WIDTH - IL;
	localparam int PW = DW + COORD_WIDTH;

	localparam logic signed [COORD_WIDTH-1:0] SAT_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] SAT_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic [DW-1:0]          diff;
	logic [DW-1:0]          dm_c;
	logic [COORD_WIDTH-1:0] im_c;
	logic                   neg_c;

	logic [DW-1:0]          dm_s1;
	logic [COORD_WIDTH-1:0] im_s1;
	logic                   neg_s1;

	logic [DW+IL-1:0]       pp_lo_s2;
	logic [DW+IH-1:0]       pp_hi_s2;
	logic                   neg_s2;

	logic [PW-1:0]          prod;
	logic [PW-1:0]          shifted;
	logic                   ovf;
	logic [COORD_WIDTH-1:0] mag;
	logic signed [COORD_WIDTH-1:0] dist_c;
	logic signed [COORD_WIDTH-1:0] dist_s3;

	// Stage 1: exact difference, turned into magnitude and sign.
	always_comb begin
		diff  = {corner[COORD_WIDTH-1], corner} - {origin[COORD_WIDTH-1], origin};
		dm_c  = diff[DW-1] ? (~diff + DW'(1)) : diff;
		im_c  = inv_dir[COORD_WIDTH-1] ? (~inv_dir + COORD_WIDTH'(1)) : inv_dir;
		neg_c = diff[DW-1] ^ inv_dir[COORD_WIDTH-1];
	end

	always_ff @(posedge clk) begin
		dm_s1  <= dm_c;
		im_s1  <= im_c;
		neg_s1 <= neg_c;
	end

	// Stage 2: two partial products over the halves of the reciprocal.
	always_ff @(posedge clk) begin
		pp_lo_s2 <= dm_s1 * im_s1[IL-1:0];
		pp_hi_s2 <= dm_s1 * im_s1[COORD_WIDTH-1:IL];
		neg_s2   <= neg_s1;
	end

	// Stage 3: sum the partial products, truncate the fraction, saturate.
	always_comb begin
		prod    = {pp_hi_s2, {IL{1'b0}}} + PW'(pp_lo_s2);
		shifted = prod >> FRAC_BITS;
		ovf     = |shifted[PW-1:COORD_WIDTH-1];
		mag     = {1'b0, shifted[COORD_WIDTH-2:0]};
		if (neg_s2) begin
			dist_c = ovf ? SAT_NEG : -$signed(mag);
		end else begin
			dist_c = ovf ? SAT_POS : $signed(mag);
		end
	end

	always_ff @(posedge clk) begin
		dist_s3 <= dist_c;
	end

	assign distance = dist_s3;

endmodule

FILE: sv/rbsi_interval.sv
module rbsi_interval
	import rbsi_pkg::*;
#(
	parameter int COORD_WIDTH = RBSI_COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] distance [NUM_LANES],
	input  logic signed [COORD_WIDTH-1:0] ray_t_max,
	input  logic [COORD_WIDTH-2:0]        tolerance,
	output logic                          out_valid,
	output logic                          out_hit,
	output logic signed [COORD_WIDTH-1:0] out_t_near,
	output logic signed [COORD_WIDTH-1:0] out_t_far
);

	logic signed [COORD_WIDTH-1:0] lo_s4 [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] hi_s4 [NUM_AXES];
	logic                          valid_s4;

	logic signed [COORD_WIDTH-1:0] tmin_s5, tmax_s5, lo2_s5, hi2_s5;
	logic                          miss_s5, valid_s5;

	logic signed [COORD_WIDTH-1:0] tmin_s6, tmax_s6;
	logic                          miss_s6, valid_s6;

	logic signed [COORD_WIDTH-1:0] tol_s;
	logic                          hit_c;

	logic signed [COORD_WIDTH-1:0] t_near_s7, t_far_s7;
	logic                          hit_s7, valid_s7;

	// Valid bits of stages 4 to 7.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Stage 4: order the two slab distances of each axis.
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_AXES; k++) begin
			if (distance[k] > distance[NUM_AXES+k]) begin
				lo_s4[k] <= distance[NUM_AXES+k];
				hi_s4[k] <= distance[k];
			end else begin
				lo_s4[k] <= distance[k];
				hi_s4[k] <= distance[NUM_AXES+k];
			end
		end
	end

	// Stage 5: intersect the x and y intervals.
	always_ff @(posedge clk) begin
		tmin_s5 <= (lo_s4[1] > lo_s4[0]) ? lo_s4[1] : lo_s4[0];
		tmax_s5 <= (hi_s4[1] < hi_s4[0]) ? hi_s4[1] : hi_s4[0];
		miss_s5 <= (lo_s4[0] > hi_s4[1]) || (lo_s4[1] > hi_s4[0]);
		lo2_s5  <= lo_s4[2];
		hi2_s5  <= hi_s4[2];
	end

	// Stage 6: narrow the interval with the z slab.
	always_ff @(posedge clk) begin
		tmin_s6 <= (lo2_s5 > tmin_s5) ? lo2_s5 : tmin_s5;
		tmax_s6 <= (hi2_s5 < tmax_s5) ? hi2_s5 : tmax_s5;
		miss_s6 <= miss_s5 || (tmin_s5 > hi2_s5) || (lo2_s5 > tmax_s5);
	end

	// Stage 7: range and tolerance checks, clamp of the near distance.
	always_comb begin
		tol_s = $signed({1'b0, tolerance});
		hit_c = !miss_s6 && !(tmin_s6 > ray_t_max) &&
			!((tmin_s6 < tol_s) && (tmax_s6 < tol_s));
	end

	always_ff @(posedge clk) begin
		hit_s7    <= hit_c;
		t_near_s7 <= (hit_c && !(tmin_s6 < tol_s)) ? tmin_s6 : '0;
		t_far_s7  <= hit_c ? tmax_s6 : '0;
	end

	assign out_valid  = valid_s7;
	assign out_hit    = hit_s7;
	assign out_t_near = t_near_s7;
	assign out_t_far  = t_far_s7;

endmodule

FILE: sv/ray_box_slab_intersect.sv
// Ray versus axis-aligned box slab test, one box per beat.
// Path: a box passes the registered slab stages, then the registered interval stages.
// Throughput: one box per cycle; the six slab multipliers are split in two halves.
// Reset: arst_n clears all valid bits and loads the register reset values.
// The receiver cannot stall, so busy stays low and no beat is ever held.
module ray_box_slab_intersect
	import rbsi_pkg::*;
#(
	parameter int COORD_WIDTH = RBSI_COORD_WIDTH,
	parameter int FRAC_BITS   = RBSI_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] box_min_x,
	input  logic signed [COORD_WIDTH-1:0] box_min_y,
	input  logic signed [COORD_WIDTH-1:0] box_min_z,
	input  logic signed [COORD_WIDTH-1:0] box_max_x,
	input  logic signed [COORD_WIDTH-1:0] box_max_y,
	input  logic signed [COORD_WIDTH-1:0] box_max_z,
	output logic                          done,
	output logic                          hit,
	output logic signed [COORD_WIDTH-1:0] t_near,
	output logic signed [COORD_WIDTH-1:0] t_far,
	input  logic                          cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_wdata
);

	logic signed [COORD_WIDTH-1:0] origin [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] inv_dir [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] ray_t_max;
	logic [COORD_WIDTH-2:0]        tolerance;

	logic signed [COORD_WIDTH-1:0] corner [NUM_LANES];
	logic signed [COORD_WIDTH-1:0] distance [NUM_LANES];

	logic valid_s1, valid_s2, valid_s3;

	// The pipeline never stalls.
	assign busy = 1'b0;

	rbsi_cfg #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.origin   (origin),
		.inv_dir  (inv_dir),
		.ray_t_max(ray_t_max),
		.tolerance(tolerance)
	);

	// Lanes 0 to 2 take the lower corner, lanes 3 to 5 the upper corner.
	assign corner[0] = box_min_x;
	assign corner[1] = box_min_y;
	assign corner[2] = box_min_z;
	assign corner[3] = box_max_x;
	assign corner[4] = box_max_y;
	assign corner[5] = box_max_z;

	// Valid bits of the slab stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// One slab distance unit per box corner coordinate.
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		rbsi_slab #(
			.COORD_WIDTH(COORD_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_slab (
			.clk     (clk),
			.corner  (corner[g]),
			.origin  (origin[g % NUM_AXES]),
			.inv_dir (inv_dir[g % NUM_AXES]),
			.distance(distance[g])
		);
	end

	rbsi_interval #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_interval (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.distance  (distance),
		.ray_t_max (ray_t_max),
		.tolerance (tolerance),
		.out_valid (done),
		.out_hit   (hit),
		.out_t_near(t_near),
		.out_t_far (t_far)
	);

endmodule

FILE: dv/tb_ray_box_slab_intersect.sv
`timescale 1ns / 100ps

module tb_ray_box_slab_intersect;
	import rbsi_pkg::*;

	localparam int CW           = RBSI_COORD_WIDTH;
	localparam int FB           = RBSI_FRAC_BITS;
	localparam int PIPE_LATENCY = 7;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;
	localparam int NUM_REGS     = 1 << CFG_INDEX_W;

	localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
	localparam longint COORD_MIN = -(longint'(1) << (CW - 1));

	localparam logic [CW-1:0] ONE      = CW'(1) << FB;
	localparam logic [CW-1:0] MOST_POS = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] MOST_NEG = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic [CW-1:0] min_x, min_y, min_z;
		logic [CW-1:0] max_x, max_y, max_z;
	} box_t;

	typedef struct packed {
		logic          hit;
		logic [CW-1:0] t_near;
		logic [CW-1:0] t_far;
	} hit_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic signed [CW-1:0]   box_min_x, box_min_y, box_min_z;
	logic signed [CW-1:0]   box_max_x, box_max_y, box_max_z;
	logic                   done;
	logic                   hit;
	logic signed [CW-1:0]   t_near;
	logic signed [CW-1:0]   t_far;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CW-1:0]          cfg_wdata;

	// Shadow copy of the ray registers, and the hits still owed by the block.
	logic [CW-1:0] ray_cfg [NUM_REGS];
	hit_result_t   expected_hits [$];
	hit_result_t   oldest_hit;
	int            mismatch_count = 0;
	int            cycle_count = 0;
	int            idle_pct;

	ray_box_slab_intersect dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.box_min_x (box_min_x),
		.box_min_y (box_min_y),
		.box_min_z (box_min_z),
		.box_max_x (box_max_x),
		.box_max_y (box_max_y),
		.box_max_z (box_max_z),
		.done      (done),
		.hit       (hit),
		.t_near    (t_near),
		.t_far     (t_far),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop in case the block stops producing hits.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ray_box_slab_intersect: mismatch");
			$finish;
		end
	end

	function automatic longint coord_of(logic [CW-1:0] v);
		return longint'($signed(v));
	endfunction

	function automatic logic [CW-1:0] clamp_coord(longint v);
		if (v > COORD_MAX)
			return MOST_POS;
		if (v < COORD_MIN)
			return MOST_NEG;
		return v[CW-1:0];
	endfunction

	// Distance to one slab plane: exact product, truncated toward zero, saturated.
	function automatic longint slab_distance(longint corner, longint org, longint inv_dir);
		longint      diff;
		logic [63:0] diff_mag;
		logic [63:0] inv_mag;
		logic [63:0] dist_mag;
		bit          negative;
		diff = corner - org;
		negative = (diff < 0);
		diff_mag = negative ? -diff : diff;
		if (inv_dir < 0) begin
			inv_mag = -inv_dir;
			negative = !negative;
		end else begin
			inv_mag = inv_dir;
		end
		dist_mag = (diff_mag * inv_mag) >> FB;
		if (dist_mag == 0)
			return 0;
		if (negative) begin
			if (dist_mag >= 64'(-COORD_MIN))
				return COORD_MIN;
			return -longint'(dist_mag);
		end
		if (dist_mag > 64'(COORD_MAX))
			return COORD_MAX;
		return longint'(dist_mag);
	endfunction

	// Narrows the entry/exit interval over the three axes and applies the ray limits.
	function automatic hit_result_t predict_hit(box_t b);
		hit_result_t r;
		longint      lo_c [NUM_AXES];
		longint      hi_c [NUM_AXES];
		longint      near_d, far_d, swap_d;
		longint      t_lo, t_hi, t_cap, tol;
		bit          is_hit;
		int          ax;
		lo_c[0] = coord_of(b.min_x);
		lo_c[1] = coord_of(b.min_y);
		lo_c[2] = coord_of(b.min_z);
		hi_c[0] = coord_of(b.max_x);
		hi_c[1] = coord_of(b.max_y);
		hi_c[2] = coord_of(b.max_z);
		is_hit = 1'b1;
		t_lo = 0;
		t_hi = 0;
		for (ax = 0; ax < NUM_AXES && is_hit; ax++) begin
			near_d = slab_distance(lo_c[ax], coord_of(ray_cfg[REG_ORIGIN_X + ax]),
				coord_of(ray_cfg[REG_INV_DIR_X + ax]));
			far_d = slab_distance(hi_c[ax], coord_of(ray_cfg[REG_ORIGIN_X + ax]),
				coord_of(ray_cfg[REG_INV_DIR_X + ax]));
			if (near_d > far_d) begin
				swap_d = near_d;
				near_d = far_d;
				far_d = swap_d;
			end
			if (ax == 0) begin
				t_lo = near_d;
				t_hi = far_d;
			end else if (t_lo > far_d || near_d > t_hi) begin
				is_hit = 1'b0;
			end else begin
				if (near_d > t_lo)
					t_lo = near_d;
				if (far_d < t_hi)
					t_hi = far_d;
			end
		end
		t_cap = coord_of(ray_cfg[REG_RAY_T_MAX]);
		tol = longint'(ray_cfg[REG_TOLERANCE][CW-2:0]);
		if (is_hit && t_lo > t_cap)
			is_hit = 1'b0;
		if (is_hit && t_lo < tol && t_hi < tol)
			is_hit = 1'b0;
		if (is_hit && t_lo < tol)
			t_lo = 0;
		if (!is_hit) begin
			t_lo = 0;
			t_hi = 0;
		end
		r.hit = is_hit;
		r.t_near = t_lo[CW-1:0];
		r.t_far = t_hi[CW-1:0];
		return r;
	endfunction

	function automatic box_t make_box(logic [CW-1:0] lx, logic [CW-1:0] ly, logic [CW-1:0] lz,
		logic [CW-1:0] hx, logic [CW-1:0] hy, logic [CW-1:0] hz);
		box_t b;
		b.min_x = lx;
		b.min_y = ly;
		b.min_z = lz;
		b.max_x = hx;
		b.max_y = hy;
		b.max_z = hz;
		return b;
	endfunction

	// Mostly boxes placed around a point on the current ray, so that hits are common;
	// the rest are loose boxes near the origin, raw noise and extreme corner values.
	function automatic box_t random_box();
		logic [CW-1:0] c_lo [NUM_AXES];
		logic [CW-1:0] c_hi [NUM_AXES];
		logic [CW-1:0] tmp;
		longint        t_on_ray, org, inv_dir, p;
		int            kind, ax;
		kind = $urandom_range(0, 99);
		t_on_ray = longint'($urandom_range(0, 150 << 16)) - (longint'(20) << 16);
		for (ax = 0; ax < NUM_AXES; ax++) begin
			org = coord_of(ray_cfg[REG_ORIGIN_X + ax]);
			inv_dir = coord_of(ray_cfg[REG_INV_DIR_X + ax]);
			if (kind < 60) begin
				p = (inv_dir == 0) ? org : org + (t_on_ray * (longint'(1) << FB)) / inv_dir;
				c_lo[ax] = clamp_coord(p - longint'($urandom_range(0, 3 << 16)));
				c_hi[ax] = clamp_coord(p + longint'($urandom_range(0, 3 << 16)));
			end else if (kind < 85) begin
				c_lo[ax] = clamp_coord(org + longint'($urandom_range(0, 100 << 16))
					- (longint'(50) << 16));
				c_hi[ax] = clamp_coord(org + longint'($urandom_range(0, 100 << 16))
					- (longint'(50) << 16));
			end else if (kind < 97) begin
				c_lo[ax] = $urandom;
				c_hi[ax] = $urandom;
			end else begin
				c_lo[ax] = $urandom_range(0, 1) ? MOST_POS : MOST_NEG;
				c_hi[ax] = $urandom_range(0, 1) ? MOST_POS : MOST_NEG;
			end
			// Corners may come in either order.
			if ($urandom_range(0, 3) == 0) begin
				tmp = c_lo[ax];
				c_lo[ax] = c_hi[ax];
				c_hi[ax] = tmp;
			end
		end
		return make_box(c_lo[0], c_lo[1], c_lo[2], c_hi[0], c_hi[1], c_hi[2]);
	endfunction

	// Drives one box and records its expected hit once the beat is taken.
	task automatic send_box(box_t b);
		@(negedge clk);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		start = 1'b1;
		box_min_x = b.min_x;
		box_min_y = b.min_y;
		box_min_z = b.min_z;
		box_max_x = b.max_x;
		box_max_y = b.max_y;
		box_max_z = b.max_z;
		do @(posedge clk); while (busy !== 1'b0);
		expected_hits.push_back(predict_hit(b));
	endtask

	// Stops sending and lets every outstanding hit come back.
	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CW-1:0] value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		ray_cfg[idx] = (idx == REG_TOLERANCE) ? {1'b0, value[CW-2:0]} : value;
	endtask

	task automatic flag_mismatch(string what, logic [CW-1:0] want, logic [CW-1:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t ns: %s expected %h got %h", $time, what, want, got);
	endtask

	// Each hit beat is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_hits.size() == 0) begin
				flag_mismatch("hit beat with nothing expected, t_near", '0, t_near);
			end else begin
				oldest_hit = expected_hits.pop_front();
				if (hit !== oldest_hit.hit)
					flag_mismatch("hit", CW'(oldest_hit.hit), CW'(hit));
				if (t_near !== oldest_hit.t_near)
					flag_mismatch("t_near", oldest_hit.t_near, t_near);
				if (t_far !== oldest_hit.t_far)
					flag_mismatch("t_far", oldest_hit.t_far, t_far);
			end
		end
	end

	// Reset values, ordinary hits, misses behind the ray and beside the box, clamping and ties.
	task automatic test_default_ray();
		idle_pct = 0;
		send_box(make_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
		send_box(make_box(2 * ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE));
		send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
		send_box(make_box(-(3 * ONE), -(3 * ONE), -(3 * ONE), -(2 * ONE), -(2 * ONE),
			-(2 * ONE)));
		send_box(make_box(ONE, 3 * ONE, '0, 2 * ONE, 4 * ONE, 5 * ONE));
		send_box(make_box(ONE, 2 * ONE, '0, 2 * ONE, 3 * ONE, 5 * ONE));
		send_box(make_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS));
		send_box(make_box(MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS));
		send_box(make_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG));
		send_box(make_box(CW'(66), CW'(66), CW'(66), ONE, ONE, ONE));
		send_box(make_box(CW'(65), CW'(65), CW'(65), ONE, ONE, ONE));
		wait_idle();
	endtask

	// Ray end, zero tolerance, zero and saturating reciprocal directions.
	task automatic test_ray_limits();
		idle_pct = 0;
		write_reg(REG_RAY_T_MAX, ONE + (ONE >> 1));
		write_reg(REG_TOLERANCE, '0);
		send_box(make_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
		send_box(make_box(2 * ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE, 3 * ONE));
		send_box(make_box(ONE + (ONE >> 1), ONE, ONE, 3 * ONE, 3 * ONE, 3 * ONE));
		send_box(make_box('0, '0, '0, '0, '0, '0));
		wait_idle();
		write_reg(REG_INV_DIR_X, '0);
		send_box(make_box(5 * ONE, -ONE, -ONE, 9 * ONE, ONE, ONE));
		send_box(make_box(5 * ONE, ONE, ONE, 9 * ONE, 2 * ONE, 2 * ONE));
		wait_idle();
		write_reg(REG_ORIGIN_X, MOST_NEG);
		write_reg(REG_INV_DIR_X, MOST_POS);
		write_reg(REG_INV_DIR_Y, MOST_POS);
		write_reg(REG_INV_DIR_Z, MOST_NEG);
		write_reg(REG_RAY_T_MAX, MOST_POS);
		send_box(make_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS));
		send_box(make_box(ONE, ONE, -(2 * ONE), 2 * ONE, 2 * ONE, -ONE));
		send_box(make_box(-(2 * ONE), -ONE, ONE, -ONE, CW'(1), 2 * ONE));
		wait_idle();
		write_reg(REG_TOLERANCE, MOST_POS);
		send_box(make_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS));
		send_box(make_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
		wait_idle();
	endtask

	// The two opposite corners of the register space.
	task automatic test_extreme_rays();
		int ax, n;
		for (int corner = 0; corner < 2; corner++) begin
			for (ax = 0; ax < NUM_AXES; ax++) begin
				write_reg(CFG_INDEX_W'(REG_ORIGIN_X + ax), corner ? MOST_POS : MOST_NEG);
				write_reg(CFG_INDEX_W'(REG_INV_DIR_X + ax), corner ? MOST_NEG : MOST_POS);
			end
			write_reg(REG_RAY_T_MAX, corner ? MOST_POS : MOST_NEG);
			write_reg(REG_TOLERANCE, corner ? '0 : MOST_POS);
			idle_pct = 68;
			for (n = 0; n < 20; n++)
				send_box(random_box());
			wait_idle();
		end
	endtask

	// Random rays, each followed by a burst of boxes under a different idle pattern.
	task automatic test_random_rays();
		int            phase, ax, n;
		logic [CW-1:0] value;
		for (phase = 0; phase < 10; phase++) begin
			for (ax = 0; ax < NUM_AXES; ax++) begin
				if ($urandom_range(0, 4) == 0)
					value = $urandom;
				else
					value = $urandom_range(0, 200 << 16) - (100 << 16);
				write_reg(CFG_INDEX_W'(REG_ORIGIN_X + ax), value);
				case ($urandom_range(0, 9))
					0: value = '0;
					1: value = MOST_POS;
					2: value = MOST_NEG;
					3: value = $urandom;
					default: begin
						value = $urandom_range(1 << (FB - 4), 1 << (FB + 4));
						if ($urandom_range(0, 1))
							value = -value;
					end
				endcase
				write_reg(CFG_INDEX_W'(REG_INV_DIR_X + ax), value);
			end
			case ($urandom_range(0, 5))
				0: value = MOST_POS;
				1: value = $urandom;
				default: value = $urandom_range(0, 120 << 16);
			endcase
			write_reg(REG_RAY_T_MAX, value);
			case ($urandom_range(0, 7))
				0: value = '0;
				1: value = CW'(TOLERANCE_RESET);
				2: value = MOST_POS;
				3: value = $urandom;
				default: value = $urandom_range(0, 1 << FB);
			endcase
			write_reg(REG_TOLERANCE, value);
			case (phase % 3)
				0: idle_pct = 0;
				1: idle_pct = 68;
				default: idle_pct = 37;
			endcase
			for (n = 0; n < 70; n++)
				send_box(random_box());
			wait_idle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		box_min_x = '0;
		box_min_y = '0;
		box_min_z = '0;
		box_max_x = '0;
		box_max_y = '0;
		box_max_z = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_pct = 0;
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			ray_cfg[REG_ORIGIN_X + ax] = '0;
			ray_cfg[REG_INV_DIR_X + ax] = ONE;
		end
		ray_cfg[REG_RAY_T_MAX] = MOST_POS;
		ray_cfg[REG_TOLERANCE] = CW'(TOLERANCE_RESET);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_ray();
		test_ray_limits();
		test_extreme_rays();
		test_random_rays();
		wait_idle();

		if (mismatch_count == 0)
			$display("ray_box_slab_intersect: match");
		else
			$display("ray_box_slab_intersect: mismatch");
		$finish;
	end

endmodule

FILE: ray_box_slab_intersect.f
sv/rbsi_pkg.sv
sv/rbsi_cfg.sv
sv/rbsi_slab.sv
sv/rbsi_interval.sv
sv/ray_box_slab_intersect.sv
dv/tb_ray_box_slab_intersect.sv
